// ----- src/pubp_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helper functions of the primal update box projection unit
// no dependencies

package pubp_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned InW   = 288;
  localparam int unsigned OutW  = 64;

  localparam logic [31:0]        CfgOne = 32'h0001_0000;
  localparam logic [63:0]        Half64 = 64'h0000_0000_0000_8000;
  localparam logic [79:0]        Half80 = 80'h8000;
  localparam logic [59:0]        ILim   = '1;
  localparam logic signed [63:0] ILim64 = 64'sh0FFF_FFFF_FFFF_FFFF;
  localparam logic signed [31:0] DMax   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] DMin   = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CFG_MODE         = 2'd0,
    CFG_STEP_SIZE    = 2'd1,
    CFG_PROX_WEIGHT  = 2'd2,
    CFG_OUTPUT_SCALE = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    BND_LOWER = 1'b0,
    BND_UPPER = 1'b1
  } bound_sel_e;

  typedef struct packed {
    logic signed [31:0] u_re;
    logic signed [31:0] u_im;
    logic signed [31:0] grad_re;
    logic signed [31:0] grad_im;
    logic signed [31:0] anchor_re;
    logic signed [31:0] anchor_im;
    logic [30:0]        weight;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic               real_only;
  } in_t;

  // step result: raw sum, mode 0 result and mode 1 divisor
  typedef struct packed {
    logic signed [61:0] s_re;
    logic signed [61:0] s_im;
    logic signed [31:0] t0_re;
    logic signed [31:0] t0_im;
    logic [47:0]        den;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               ronly;
  } step_t;

  typedef struct packed {
    logic signed [32:0] re;
    logic signed [32:0] im;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               ronly;
  } vec_t;

  typedef struct packed {
    vec_t        v;
    logic [31:0] m;
  } mvec_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? (~x + 32'd1) : x;
    return r;
  endfunction

  // rounded shift by the fraction width, operand below 2^63
  function automatic logic [47:0] rnd_q(input logic [63:0] p);
    logic [63:0] t;
    t = p + Half64;
    return t[63:16];
  endfunction

  // apply sign to a magnitude and saturate to the data range
  function automatic logic signed [31:0] sat_sign(input logic neg, input logic [33:0] q,
                                                  input logic big);
    logic lim;
    logic signed [31:0] r;
    lim = big || (q >= 34'h0_8000_0000);
    if (neg) begin
      r = lim ? DMin : (~q[31:0] + 32'd1);
    end else begin
      r = lim ? DMax : q[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x > 33'(DMax)) begin
      r = DMax;
    end else if (x < 33'(DMin)) begin
      r = DMin;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/pubp_step.sv -----
`timescale 1ns / 1ps
// seven stage front end: gradient and anchor products, sum and mode 0 output scale
// depends on pubp_pkg

module pubp_step import pubp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        mode_i,
  input  logic [31:0] step_size_i,
  input  logic [31:0] prox_weight_i,
  input  logic [31:0] output_scale_i,
  input  logic        in_vld_i,
  input  in_t         in_i,
  output logic        out_vld_o,
  output step_t       out_o
);

  logic [6:0] vld_q;

  // stage 1
  logic signed [31:0] u1_q [2];
  logic signed [31:0] a1_q [2];
  logic               gn1_q [2];
  logic [63:0]        pg1_q [2];
  logic [62:0]        pc1_q;
  logic signed [31:0] lo1_q, hi1_q;
  logic               ro1_q;
  // stage 2
  logic signed [31:0] u2_q [2];
  logic signed [31:0] a2_q [2];
  logic signed [48:0] pgs2_q [2];
  logic [47:0]        c2_q;
  logic signed [31:0] lo2_q, hi2_q;
  logic               ro2_q;
  // stage 3
  logic signed [31:0] u3_q [2];
  logic               an3_q [2];
  logic [63:0]        pal3_q [2];
  logic [47:0]        pah3_q [2];
  logic signed [48:0] pgs3_q [2];
  logic [47:0]        c3_q;
  logic signed [31:0] lo3_q, hi3_q;
  logic               ro3_q;
  // stage 4
  logic signed [31:0] u4_q [2];
  logic signed [48:0] pgs4_q [2];
  logic signed [60:0] pas4_q [2];
  logic [47:0]        c4_q;
  logic signed [31:0] lo4_q, hi4_q;
  logic               ro4_q;
  // stage 5
  logic signed [61:0] s5_q [2];
  logic [47:0]        c5_q;
  logic signed [31:0] lo5_q, hi5_q;
  logic               ro5_q;
  // stage 6
  logic signed [61:0] s6_q [2];
  logic               n6_q [2];
  logic               big6_q [2];
  logic [63:0]        pl6_q [2];
  logic [46:0]        ph6_q [2];
  logic [47:0]        c6_q;
  logic signed [31:0] lo6_q, hi6_q;
  logic               ro6_q;
  // stage 7
  step_t              out_q;

  logic signed [31:0] gin [2];
  logic signed [31:0] ain [2];
  logic signed [31:0] uin [2];
  logic [47:0]        coef;
  logic signed [48:0] pgs2_d [2];
  logic signed [60:0] pas4_d [2];
  logic signed [61:0] s5_d [2];
  logic [59:0]        m6 [2];
  logic signed [31:0] t0_d [2];

  always_comb begin
    logic [47:0] pgq;
    logic [79:0] sum80;
    logic [63:0] q;
    logic [59:0] pam;
    logic signed [63:0] sum64;
    logic [61:0] mt;
    logic big;
    uin[0] = in_i.u_re;
    uin[1] = in_i.u_im;
    gin[0] = in_i.grad_re;
    gin[1] = in_i.grad_im;
    ain[0] = in_i.anchor_re;
    ain[1] = in_i.anchor_im;
    coef   = mode_i ? c2_q : {16'd0, prox_weight_i};
    for (int k = 0; k < 2; k++) begin
      pgq       = rnd_q(pg1_q[k]);
      pgs2_d[k] = gn1_q[k] ? (49'd0 - {1'b0, pgq}) : {1'b0, pgq};
      sum80     = {16'd0, pal3_q[k]} + {pah3_q[k], 32'd0} + Half80;
      q         = sum80[79:16];
      pam       = (q > {4'd0, ILim}) ? ILim : q[59:0];
      pas4_d[k] = an3_q[k] ? (61'd0 - {1'b0, pam}) : {1'b0, pam};
      sum64     = 64'(u4_q[k]) - 64'(pgs4_q[k]) + 64'(pas4_q[k]);
      if (sum64 > ILim64) begin
        s5_d[k] = 62'(ILim64);
      end else if (sum64 < -ILim64) begin
        s5_d[k] = 62'(-ILim64);
      end else begin
        s5_d[k] = 62'(sum64);
      end
      mt        = s5_q[k][61] ? (62'd0 - s5_q[k]) : s5_q[k];
      m6[k]     = mt[59:0];
      sum80     = {16'd0, pl6_q[k]} + {1'b0, ph6_q[k], 32'd0} + Half80;
      q         = sum80[79:16];
      big       = (big6_q[k] && (output_scale_i != 32'd0)) || (q[63:34] != 30'd0);
      t0_d[k]   = sat_sign(n6_q[k], q[33:0], big);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[5:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 2; k++) begin
        u1_q[k]   <= uin[k];
        a1_q[k]   <= ain[k];
        gn1_q[k]  <= gin[k][31];
        pg1_q[k]  <= mag32(gin[k]) * step_size_i;

        u2_q[k]   <= u1_q[k];
        a2_q[k]   <= a1_q[k];
        pgs2_q[k] <= pgs2_d[k];

        u3_q[k]   <= u2_q[k];
        an3_q[k]  <= a2_q[k][31];
        pal3_q[k] <= mag32(a2_q[k]) * coef[31:0];
        pah3_q[k] <= mag32(a2_q[k]) * coef[47:32];
        pgs3_q[k] <= pgs2_q[k];

        u4_q[k]   <= u3_q[k];
        pgs4_q[k] <= pgs3_q[k];
        pas4_q[k] <= pas4_d[k];

        s5_q[k]   <= s5_d[k];

        s6_q[k]   <= s5_q[k];
        n6_q[k]   <= s5_q[k][61];
        big6_q[k] <= (m6[k][59:47] != 13'd0);
        pl6_q[k]  <= m6[k][31:0] * output_scale_i;
        ph6_q[k]  <= m6[k][46:32] * output_scale_i;
      end
      pc1_q <= prox_weight_i * in_i.weight;
      lo1_q <= in_i.lower_bound;
      hi1_q <= in_i.upper_bound;
      ro1_q <= in_i.real_only;

      c2_q  <= rnd_q({1'b0, pc1_q});
      lo2_q <= lo1_q;
      hi2_q <= hi1_q;
      ro2_q <= ro1_q;

      c3_q  <= c2_q;
      lo3_q <= lo2_q;
      hi3_q <= hi2_q;
      ro3_q <= ro2_q;

      c4_q  <= c3_q;
      lo4_q <= lo3_q;
      hi4_q <= hi3_q;
      ro4_q <= ro3_q;

      c5_q  <= c4_q;
      lo5_q <= lo4_q;
      hi5_q <= hi4_q;
      ro5_q <= ro4_q;

      c6_q  <= c5_q;
      lo6_q <= lo5_q;
      hi6_q <= hi5_q;
      ro6_q <= ro5_q;

      out_q.s_re  <= s6_q[0];
      out_q.s_im  <= s6_q[1];
      out_q.t0_re <= t0_d[0];
      out_q.t0_im <= t0_d[1];
      out_q.den   <= c6_q + {16'd0, CfgOne};
      out_q.lo    <= lo6_q;
      out_q.hi    <= hi6_q;
      out_q.ronly <= ro6_q;
    end
  end

  assign out_vld_o = vld_q[6];
  assign out_o     = out_q;

endmodule

// ----- src/pubp_div.sv -----
`timescale 1ns / 1ps
// mode 1 normalizing divider, one quotient bit per stage, both parts in parallel
// depends on pubp_pkg

module pubp_div import pubp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  mode_i,
  input  logic  in_vld_i,
  input  step_t in_i,
  output logic  out_vld_o,
  output vec_t  out_o
);

  localparam int unsigned NStg = 33;

  typedef struct packed {
    logic [47:0]        rem;
    logic [32:0]        q;
    logic [32:0]        bits;
    logic               ovf;
    logic               neg;
    logic signed [31:0] t0;
  } dlane_t;

  typedef struct packed {
    dlane_t [1:0]       ln;
    logic [47:0]        den;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               ronly;
  } dst_t;

  logic [NStg:0] vld_q;
  dst_t          st_q [NStg+1];
  dst_t          st_d [NStg+1];
  logic          out_vld_q;
  vec_t          out_q, out_d;

  always_comb begin
    logic signed [61:0] s [2];
    logic [61:0] mg;
    logic [48:0] r2;
    logic [48:0] df;
    logic [33:0] qr;
    logic        rnd;
    logic signed [31:0] t [2];
    s[0] = in_i.s_re;
    s[1] = in_i.s_im;
    st_d[0].den   = in_i.den;
    st_d[0].lo    = in_i.lo;
    st_d[0].hi    = in_i.hi;
    st_d[0].ronly = in_i.ronly;
    st_d[0].ln[0].t0 = in_i.t0_re;
    st_d[0].ln[1].t0 = in_i.t0_im;
    for (int k = 0; k < 2; k++) begin
      mg = s[k][61] ? (62'd0 - s[k]) : s[k];
      st_d[0].ln[k].rem  = {4'd0, mg[60:17]};
      st_d[0].ln[k].ovf  = ({4'd0, mg[60:17]} >= in_i.den);
      st_d[0].ln[k].bits = {mg[16:0], 16'd0};
      st_d[0].ln[k].q    = '0;
      st_d[0].ln[k].neg  = s[k][61];
    end
    for (int i = 1; i <= NStg; i++) begin
      st_d[i] = st_q[i-1];
      for (int k = 0; k < 2; k++) begin
        r2 = {st_q[i-1].ln[k].rem, st_q[i-1].ln[k].bits[32]};
        df = r2 - {1'b0, st_q[i-1].den};
        if (r2 >= {1'b0, st_q[i-1].den}) begin
          st_d[i].ln[k].rem = df[47:0];
          st_d[i].ln[k].q   = {st_q[i-1].ln[k].q[31:0], 1'b1};
        end else begin
          st_d[i].ln[k].rem = r2[47:0];
          st_d[i].ln[k].q   = {st_q[i-1].ln[k].q[31:0], 1'b0};
        end
        st_d[i].ln[k].bits = {st_q[i-1].ln[k].bits[31:0], 1'b0};
      end
    end
    // round to nearest, ties away from zero
    for (int k = 0; k < 2; k++) begin
      rnd  = ({st_q[NStg].ln[k].rem, 1'b0} >= {1'b0, st_q[NStg].den});
      qr   = {1'b0, st_q[NStg].ln[k].q} + {33'd0, rnd};
      t[k] = mode_i ? sat_sign(st_q[NStg].ln[k].neg, qr, st_q[NStg].ln[k].ovf)
                    : st_q[NStg].ln[k].t0;
    end
    out_d.re    = 33'(t[0]);
    out_d.im    = 33'(t[1]);
    out_d.lo    = st_q[NStg].lo;
    out_d.hi    = st_q[NStg].hi;
    out_d.ronly = st_q[NStg].ronly;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q     <= {vld_q[NStg-1:0], in_vld_i};
      out_vld_q <= vld_q[NStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i <= NStg; i++) begin
        st_q[i] <= st_d[i];
      end
      out_q <= out_d;
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;

endmodule

// ----- src/pubp_sqrt.sv -----
`timescale 1ns / 1ps
// magnitude unit: squares, sum and a digit-by-digit square root, one root bit per stage
// depends on pubp_pkg

module pubp_sqrt import pubp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  in_vld_i,
  input  vec_t  in_i,
  output logic  out_vld_o,
  output mvec_t out_o
);

  localparam int unsigned NStg = 32;

  typedef struct packed {
    logic [63:0] n;
    logic [31:0] root;
    logic [33:0] rem;
    vec_t        v;
  } sst_t;

  logic [NStg+1:0] vld_q;
  logic [63:0]     sq_q [2];
  vec_t            v0_q;
  sst_t            st_q [NStg+1];
  sst_t            st_d [NStg+1];

  function automatic logic [31:0] mag33(input logic signed [32:0] x);
    logic [32:0] r;
    r = x[32] ? (33'd0 - x) : x;
    return r[31:0];
  endfunction

  always_comb begin
    logic [35:0] r4;
    logic [35:0] trial;
    logic [35:0] df;
    st_d[0].n    = sq_q[0] + sq_q[1];
    st_d[0].root = '0;
    st_d[0].rem  = '0;
    st_d[0].v    = v0_q;
    for (int i = 1; i <= NStg; i++) begin
      st_d[i]   = st_q[i-1];
      r4        = {st_q[i-1].rem, st_q[i-1].n[63:62]};
      trial     = {2'b00, st_q[i-1].root, 2'b01};
      df        = r4 - trial;
      if (r4 >= trial) begin
        st_d[i].rem  = df[33:0];
        st_d[i].root = {st_q[i-1].root[30:0], 1'b1};
      end else begin
        st_d[i].rem  = r4[33:0];
        st_d[i].root = {st_q[i-1].root[30:0], 1'b0};
      end
      st_d[i].n = {st_q[i-1].n[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NStg:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sq_q[0] <= mag33(in_i.re) * mag33(in_i.re);
      sq_q[1] <= mag33(in_i.im) * mag33(in_i.im);
      v0_q    <= in_i;
      for (int i = 0; i <= NStg; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign out_vld_o = vld_q[NStg+1];
  assign out_o.v   = st_q[NStg].v;
  assign out_o.m   = st_q[NStg].root;

endmodule

// ----- src/pubp_rescale.sv -----
`timescale 1ns / 1ps
// one bound rescale round: x * bound / m with rounding, one quotient bit per stage
// depends on pubp_pkg

module pubp_rescale import pubp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  bound_sel_e sel_i,
  input  logic       in_vld_i,
  input  mvec_t      in_i,
  output logic       out_vld_o,
  output mvec_t      out_o
);

  localparam int unsigned NStg = 32;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] q;
    logic [31:0] bits;
    logic        ovf;
    logic        neg;
  } rlane_t;

  typedef struct packed {
    rlane_t [1:0] ln;
    logic         apply;
    mvec_t        mv;
  } rst_t;

  logic [NStg+1:0] vld_q;
  logic            out_vld_q;
  logic [63:0]     num_q [2];
  logic            neg_q [2];
  logic            app_q;
  mvec_t           mv_q;
  rst_t            st_q [NStg+1];
  rst_t            st_d [NStg+1];
  mvec_t           out_q, out_d;
  logic            app_d;
  logic signed [31:0] bnd;

  function automatic logic [31:0] mag33(input logic signed [32:0] x);
    logic [32:0] r;
    r = x[32] ? (33'd0 - x) : x;
    return r[31:0];
  endfunction

  always_comb begin
    logic signed [32:0] ms;
    logic [32:0] r2;
    logic [32:0] df;
    logic [32:0] qr;
    logic [32:0] mg;
    logic        rnd;
    logic signed [32:0] res [2];
    logic signed [32:0] x [2];
    ms = $signed({1'b0, in_i.m});
    unique case (sel_i)
      BND_LOWER: begin
        bnd   = in_i.v.lo;
        app_d = (ms < 33'(in_i.v.lo));
      end
      BND_UPPER: begin
        bnd   = in_i.v.hi;
        app_d = (ms > 33'(in_i.v.hi));
      end
      default: begin
        bnd   = in_i.v.lo;
        app_d = 1'b0;
      end
    endcase
    app_d = app_d && !in_i.v.ronly && (in_i.m != 32'd0);

    st_d[0].apply = app_q;
    st_d[0].mv    = mv_q;
    for (int k = 0; k < 2; k++) begin
      st_d[0].ln[k].rem  = num_q[k][63:32];
      st_d[0].ln[k].ovf  = (num_q[k][63:32] >= mv_q.m);
      st_d[0].ln[k].bits = num_q[k][31:0];
      st_d[0].ln[k].q    = '0;
      st_d[0].ln[k].neg  = neg_q[k];
    end
    for (int i = 1; i <= NStg; i++) begin
      st_d[i] = st_q[i-1];
      for (int k = 0; k < 2; k++) begin
        r2 = {st_q[i-1].ln[k].rem, st_q[i-1].ln[k].bits[31]};
        df = r2 - {1'b0, st_q[i-1].mv.m};
        if (r2 >= {1'b0, st_q[i-1].mv.m}) begin
          st_d[i].ln[k].rem = df[31:0];
          st_d[i].ln[k].q   = {st_q[i-1].ln[k].q[30:0], 1'b1};
        end else begin
          st_d[i].ln[k].rem = r2[31:0];
          st_d[i].ln[k].q   = {st_q[i-1].ln[k].q[30:0], 1'b0};
        end
        st_d[i].ln[k].bits = {st_q[i-1].ln[k].bits[30:0], 1'b0};
      end
    end
    // round, limit the magnitude to 2^31 and put the sign back
    x[0] = st_q[NStg].mv.v.re;
    x[1] = st_q[NStg].mv.v.im;
    for (int k = 0; k < 2; k++) begin
      rnd = ({st_q[NStg].ln[k].rem, 1'b0} >= {1'b0, st_q[NStg].mv.m});
      qr  = {1'b0, st_q[NStg].ln[k].q} + {32'd0, rnd};
      mg  = (st_q[NStg].ln[k].ovf || (qr > 33'h0_8000_0000)) ? 33'h0_8000_0000 : qr;
      res[k] = st_q[NStg].ln[k].neg ? (33'd0 - mg) : mg;
      if (!st_q[NStg].apply) begin
        res[k] = x[k];
      end
    end
    out_d      = st_q[NStg].mv;
    out_d.v.re = res[0];
    out_d.v.im = res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q     <= {vld_q[NStg:0], in_vld_i};
      out_vld_q <= vld_q[NStg+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num_q[0] <= mag33(in_i.v.re) * mag32(bnd);
      num_q[1] <= mag33(in_i.v.im) * mag32(bnd);
      neg_q[0] <= in_i.v.re[32] ^ bnd[31];
      neg_q[1] <= in_i.v.im[32] ^ bnd[31];
      app_q    <= app_d;
      mv_q     <= in_i;
      for (int i = 0; i <= NStg; i++) begin
        st_q[i] <= st_d[i];
      end
      out_q <= out_d;
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;

endmodule

// ----- src/primal_update_box_projection_unit.sv -----
`timescale 1ns / 1ps
// top level of the primal update box projection unit
// depends on pubp_pkg, pubp_step, pubp_div, pubp_sqrt and pubp_rescale
//
// usage
// - slave stream takes one complex voxel per transfer: tdata holds the current value, the
//   adjoint term, the anchor, the per-voxel weight and both bounds; tuser is the real-only flag
// - master stream returns one projected complex value per transfer, real part in the low word
// - config port: write enable, register index and 32-bit data, taken on any clock edge;
//   only write it while no voxel is in flight
// - from input transfer to output valid a voxel passes the step products, the mode 1 divider,
//   the magnitude root, the two bound rescale rounds and the output register; the divider
//   and the root each retire one bit per stage, which sets the depth
// - throughput is one voxel per cycle while the receiver does not stall; every stage is always
//   used, mode 0 simply bypasses the divider result at its last stage
// - when the receiver stalls with a result waiting, the whole pipeline holds and
//   s_axis_tready_o drops; nothing is lost or repeated
// - reset clears all valid bits and loads mode 0 with step, weight and scale at 1.0

module primal_update_box_projection_unit import pubp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config write port
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  // input stream
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // u_re, u_im, grad_re, grad_im, anchor_re, anchor_im, weight, lower_bound, upper_bound
  input  logic [InW-1:0]    s_axis_tdata_i,
  // real_only
  input  logic              s_axis_tuser_i,
  // output stream
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // out_re, out_im
  output logic [OutW-1:0]   m_axis_tdata_o
);

  logic        mode_q;
  logic [31:0] step_q, pw_q, os_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      step_q <= CfgOne;
      pw_q   <= CfgOne;
      os_q   <= CfgOne;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:         mode_q <= cfg_data_i[0];
        CFG_STEP_SIZE:    step_q <= cfg_data_i;
        CFG_PROX_WEIGHT:  pw_q   <= cfg_data_i;
        CFG_OUTPUT_SCALE: os_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves whenever the output register can take a value
  logic adv;
  logic out_vld_q;
  logic signed [31:0] out_re_q, out_im_q;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  in_t in_item;
  always_comb begin
    in_item.u_re        = s_axis_tdata_i[31:0];
    in_item.u_im        = s_axis_tdata_i[63:32];
    in_item.grad_re     = s_axis_tdata_i[95:64];
    in_item.grad_im     = s_axis_tdata_i[127:96];
    in_item.anchor_re   = s_axis_tdata_i[159:128];
    in_item.anchor_im   = s_axis_tdata_i[191:160];
    in_item.weight      = s_axis_tdata_i[222:192];
    in_item.lower_bound = s_axis_tdata_i[254:223];
    in_item.upper_bound = s_axis_tdata_i[286:255];
    in_item.real_only   = s_axis_tuser_i;
  end

  logic  step_vld, div_vld, sq_vld, rl_vld, rh_vld;
  step_t step_res;
  vec_t  div_res;
  mvec_t sq_res, rl_res, rh_res;

  // step products and sum, plus the mode 0 output scale
  pubp_step u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .mode_i         (mode_q),
    .step_size_i    (step_q),
    .prox_weight_i  (pw_q),
    .output_scale_i (os_q),
    .in_vld_i       (s_axis_tvalid_i && adv),
    .in_i           (in_item),
    .out_vld_o      (step_vld),
    .out_o          (step_res)
  );

  // mode 1 division by 1 + c, saturated to the data range
  pubp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .mode_i    (mode_q),
    .in_vld_i  (step_vld),
    .in_i      (step_res),
    .out_vld_o (div_vld),
    .out_o     (div_res)
  );

  // magnitude of the saturated step value
  pubp_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_vld_i  (div_vld),
    .in_i      (div_res),
    .out_vld_o (sq_vld),
    .out_o     (sq_res)
  );

  // scale up to the lower bound, then down to the upper bound, both against the same m
  pubp_rescale u_resc_lo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .sel_i     (BND_LOWER),
    .in_vld_i  (sq_vld),
    .in_i      (sq_res),
    .out_vld_o (rl_vld),
    .out_o     (rl_res)
  );

  pubp_rescale u_resc_hi (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .sel_i     (BND_UPPER),
    .in_vld_i  (rl_vld),
    .in_i      (rl_res),
    .out_vld_o (rh_vld),
    .out_o     (rh_res)
  );

  // box clamp for real-only values, final saturation for the rest
  logic signed [31:0] out_re_d, out_im_d;
  always_comb begin
    logic signed [32:0] r;
    r = rh_res.v.re;
    if (rh_res.v.ronly) begin
      if (r < 33'(rh_res.v.lo)) begin
        r = 33'(rh_res.v.lo);
      end
      if (r > 33'(rh_res.v.hi)) begin
        r = 33'(rh_res.v.hi);
      end
      out_re_d = sat33(r);
      out_im_d = '0;
    end else begin
      out_re_d = sat33(rh_res.v.re);
      out_im_d = sat33(rh_res.v.im);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= rh_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_re_q <= out_re_d;
      out_im_q <= out_im_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_im_q, out_re_q};

endmodule
